@@ src/tocf_pkg.sv @@
// Shared types, register codes and saturation helpers for the complementary filter.
package tocf_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgValW = 23;

  localparam logic [CfgIdxW-1:0] REG_TAU  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WACC = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WVEL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WPOS = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PER  = 3'd4;

  typedef struct packed {
    logic signed [31:0] pos_measure;
    logic signed [31:0] acc_measure;
    logic               pos_flag;
    logic               vel_flag;
    logic               acc_flag;
  } in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               updated;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgValW-1:0] value;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_MLOAD = 5'b00100,
    ST_MUL   = 5'b01000,
    ST_MRES  = 5'b10000
  } st_e;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] sat_mag(input logic neg, input logic [64:0] mag);
    if (neg) begin
      if (mag >= 65'h80000000) return 32'sh80000000;
      return -$signed(mag[31:0]);
    end
    if (mag > 65'h7FFFFFFF) return 32'sh7FFFFFFF;
    return $signed(mag[31:0]);
  endfunction

endpackage

@@ src/tocf_if.sv @@
// Valid/ready channel interfaces for samples, results and register writes.
interface tocf_in_if;
  import tocf_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tocf_out_if;
  import tocf_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tocf_cfg_if;
  import tocf_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/third_order_complementary_filter_core.sv @@
// Third-order complementary filter: bit-serial divider for gains, shift-add multiplier.
// A sample that does not update is marked pending, then loaded into the output register when it is free.
// An updating sample reaches it after eight shift-add multiplies, one multiplier bit per
// cycle (3 x (20 + 51) + 2 x 17 bits), each with a load step and a result step.
// After reset or a time_constant write the first update adds five 80-bit gain divisions.
// One sample at a time; reset loads default registers and clears all estimates.
module third_order_complementary_filter_core (
  input  logic clk_i,
  input  logic rst_ni,
  tocf_in_if.sink    in_i,
  tocf_cfg_if.sink   cfg_i,
  tocf_out_if.source out_o
);
  import tocf_pkg::*;

  localparam logic [79:0] DIV_K3 = 80'd3 << 56;
  localparam logic [79:0] DIV_K5 = 80'd5 << 56;
  localparam logic [62:0] GAIN_MAX = {63{1'b1}};

  st_e st_q, st_d;
  logic [2:0] sel_q, sel_d;
  logic [6:0] dcnt_q, dcnt_d;
  logic [5:0] mcnt_q, mcnt_d;
  logic dirty_q, dirty_d;

  logic [22:0] tau_q, tau_d;
  logic [19:0] wacc_q, wacc_d, wvel_q, wvel_d, wpos_q, wpos_d;
  logic [16:0] per_q, per_d;

  logic signed [31:0] pos_est_q, pos_est_d, vel_est_q, vel_est_d, acc_est_q, acc_est_d;
  logic signed [31:0] acc_corr_q, acc_corr_d, vel_acc_q, vel_acc_d;
  logic signed [31:0] pos_corr_q, pos_corr_d, pos_int_q, pos_int_d;
  logic [62:0] kp_q, kp_d, kv_q, kv_d, ka_q, ka_d;

  logic signed [31:0] e_q, e_d, acc_meas_q, acc_meas_d, d_q, d_d;
  logic af_q, af_d, upd_q, upd_d, neg_q, neg_d, pend_q, pend_d;
  logic [50:0] p_q, p_d;

  logic [79:0] div_q, div_d;
  logic [22:0] rem_q, rem_d;
  logic [64:0] hi_q, hi_d;
  logic [63:0] lo_q, lo_d, mcand_q, mcand_d;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic [22:0] tdiv;
  logic [23:0] trial, shifted;
  logic qbit;
  logic [79:0] qfull;
  logic [62:0] gain;
  logic [64:0] sum;
  logic [31:0] e_mag;
  logic signed [33:0] s34;
  logic [33:0] s_mag;
  logic signed [31:0] corr, pint;

  assign in_i.ready  = (st_q == ST_IDLE) && !pend_q;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    st_d = st_q; sel_d = sel_q; dcnt_d = dcnt_q; mcnt_d = mcnt_q; dirty_d = dirty_q;
    tau_d = tau_q; wacc_d = wacc_q; wvel_d = wvel_q; wpos_d = wpos_q; per_d = per_q;
    pos_est_d = pos_est_q; vel_est_d = vel_est_q; acc_est_d = acc_est_q;
    acc_corr_d = acc_corr_q; vel_acc_d = vel_acc_q; pos_corr_d = pos_corr_q;
    pos_int_d = pos_int_q; kp_d = kp_q; kv_d = kv_q; ka_d = ka_q;
    e_d = e_q; acc_meas_d = acc_meas_q; d_d = d_q; af_d = af_q; upd_d = upd_q;
    neg_d = neg_q; pend_d = pend_q; p_d = p_q;
    div_d = div_q; rem_d = rem_q; hi_d = hi_q; lo_d = lo_q; mcand_d = mcand_q;
    out_valid_d = out_valid_q && !out_o.ready; out_d = out_q;

    tdiv    = (tau_q == '0) ? 23'd1 : tau_q;
    shifted = {rem_q, div_q[79]};
    trial   = shifted - {1'b0, tdiv};
    qbit    = !trial[23];
    qfull   = {div_q[78:0], qbit};
    gain    = (|qfull[79:63]) ? GAIN_MAX : qfull[62:0];
    sum     = hi_q + (lo_q[0] ? {1'b0, mcand_q} : 65'd0);
    e_mag   = e_q[31] ? 32'(-e_q) : 32'(e_q);
    s34     = {vel_est_q[31], vel_est_q, 1'b0} + {{2{d_q[31]}}, d_q};
    s_mag   = s34[33] ? 34'(-s34) : 34'(s34);
    corr    = sat_mag(neg_q, {5'd0, hi_q[64:5]});
    pint    = sat_add(pos_int_q, sat_mag(neg_q, hi_q));

    if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        REG_TAU: begin
          tau_d = cfg_i.data.value;
          dirty_d = 1'b1;
        end
        REG_WACC: wacc_d = cfg_i.data.value[19:0];
        REG_WVEL: wvel_d = cfg_i.data.value[19:0];
        REG_WPOS: wpos_d = cfg_i.data.value[19:0];
        REG_PER:  per_d = cfg_i.data.value[16:0];
        default: ;
      endcase
    end

    unique case (st_q)
      ST_IDLE: begin
        if (in_i.valid && !pend_q) begin
          upd_d = in_i.data.pos_flag && !in_i.data.vel_flag;
          af_d = in_i.data.acc_flag;
          acc_meas_d = in_i.data.acc_measure;
          e_d = sat_sub(in_i.data.pos_measure, pos_est_q);
          sel_d = '0;
          if (!(in_i.data.pos_flag && !in_i.data.vel_flag)) begin
            pend_d = 1'b1;
          end else if (dirty_q) begin
            div_d = DIV_K3; rem_d = '0; dcnt_d = 7'd79; st_d = ST_DIV;
          end else begin
            st_d = ST_MLOAD;
          end
        end
      end
      ST_DIV: begin
        rem_d = qbit ? trial[22:0] : shifted[22:0];
        div_d = qfull;
        dcnt_d = dcnt_q - 7'd1;
        if (dcnt_q == '0) begin
          rem_d = '0;
          dcnt_d = 7'd79;
          sel_d = sel_q + 3'd1;
          case (sel_q)
            3'd0: begin kp_d = gain; div_d = {1'b0, gain, 16'd0}; end
            3'd1: begin kv_d = gain; div_d = DIV_K5; end
            3'd2: div_d = {1'b0, gain, 16'd0};
            3'd3: div_d = {1'b0, gain, 16'd0};
            default: begin
              ka_d = gain; dirty_d = 1'b0; sel_d = '0; st_d = ST_MLOAD;
            end
          endcase
        end
      end
      ST_MLOAD: begin
        hi_d = '0;
        st_d = ST_MUL;
        neg_d = e_q[31];
        case (sel_q)
          3'd0: begin mcand_d = {32'd0, e_mag}; lo_d = {44'd0, wacc_q}; mcnt_d = 6'd19; end
          3'd1: begin mcand_d = {1'b0, ka_q}; lo_d = {13'd0, p_q}; mcnt_d = 6'd50; end
          3'd2: begin mcand_d = {32'd0, e_mag}; lo_d = {44'd0, wvel_q}; mcnt_d = 6'd19; end
          3'd3: begin mcand_d = {1'b0, kv_q}; lo_d = {13'd0, p_q}; mcnt_d = 6'd50; end
          3'd4: begin mcand_d = {32'd0, e_mag}; lo_d = {44'd0, wpos_q}; mcnt_d = 6'd19; end
          3'd5: begin mcand_d = {1'b0, kp_q}; lo_d = {13'd0, p_q}; mcnt_d = 6'd50; end
          3'd6: begin
            mcand_d = {32'd0, acc_est_q[31] ? 32'(-acc_est_q) : 32'(acc_est_q)};
            lo_d = {47'd0, per_q}; mcnt_d = 6'd16; neg_d = acc_est_q[31];
          end
          default: begin
            mcand_d = {30'd0, s_mag}; lo_d = {47'd0, per_q}; mcnt_d = 6'd16;
            neg_d = s34[33];
          end
        endcase
      end
      ST_MUL: begin
        hi_d = {1'b0, sum[64:1]};
        lo_d = {sum[0], lo_q[63:1]};
        mcnt_d = mcnt_q - 6'd1;
        if (mcnt_q == '0) st_d = ST_MRES;
      end
      ST_MRES: begin
        sel_d = sel_q + 3'd1;
        st_d = ST_MLOAD;
        case (sel_q)
          3'd0, 3'd2, 3'd4: p_d = {hi_q[30:0], lo_q[63:44]};
          3'd1: acc_corr_d = sat_add(acc_corr_q, corr);
          3'd3: vel_acc_d = sat_add(vel_acc_q, corr);
          3'd5: begin
            pos_corr_d = sat_add(pos_corr_q, corr);
            if (af_q) acc_est_d = sat_add(acc_meas_q, acc_corr_q);
          end
          3'd6: d_d = sat_mag(neg_q, {hi_q[63:0], lo_q[63]});
          default: begin
            pos_int_d = pint;
            pos_est_d = sat_add(pint, pos_corr_q);
            vel_acc_d = sat_add(vel_acc_q, d_q);
            vel_est_d = sat_add(vel_acc_q, d_q);
            pend_d = 1'b1;
            st_d = ST_IDLE;
          end
        endcase
      end
      default: st_d = ST_IDLE;
    endcase

    if (pend_q && !out_valid_d) begin
      pend_d = 1'b0;
      out_valid_d = 1'b1;
      out_d.position = pos_est_q;
      out_d.velocity = vel_est_q;
      out_d.acceleration = acc_est_q;
      out_d.updated = upd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; sel_q <= '0; dcnt_q <= '0; mcnt_q <= '0; dirty_q <= 1'b1;
      tau_q <= 23'd65536; wacc_q <= 20'd65536; wvel_q <= 20'd65536;
      wpos_q <= 20'd65536; per_q <= 17'd328;
      pos_est_q <= '0; vel_est_q <= '0; acc_est_q <= '0;
      acc_corr_q <= '0; vel_acc_q <= '0; pos_corr_q <= '0; pos_int_q <= '0;
      kp_q <= '0; kv_q <= '0; ka_q <= '0;
      e_q <= '0; acc_meas_q <= '0; d_q <= '0; af_q <= 1'b0; upd_q <= 1'b0;
      neg_q <= 1'b0; pend_q <= 1'b0; p_q <= '0;
      div_q <= '0; rem_q <= '0; hi_q <= '0; lo_q <= '0; mcand_q <= '0;
      out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      st_q <= st_d; sel_q <= sel_d; dcnt_q <= dcnt_d; mcnt_q <= mcnt_d; dirty_q <= dirty_d;
      tau_q <= tau_d; wacc_q <= wacc_d; wvel_q <= wvel_d; wpos_q <= wpos_d; per_q <= per_d;
      pos_est_q <= pos_est_d; vel_est_q <= vel_est_d; acc_est_q <= acc_est_d;
      acc_corr_q <= acc_corr_d; vel_acc_q <= vel_acc_d; pos_corr_q <= pos_corr_d;
      pos_int_q <= pos_int_d; kp_q <= kp_d; kv_q <= kv_d; ka_q <= ka_d;
      e_q <= e_d; acc_meas_q <= acc_meas_d; d_q <= d_d; af_q <= af_d; upd_q <= upd_d;
      neg_q <= neg_d; pend_q <= pend_d; p_q <= p_d;
      div_q <= div_d; rem_q <= rem_d; hi_q <= hi_d; lo_q <= lo_d; mcand_q <= mcand_d;
      out_valid_q <= out_valid_d; out_q <= out_d;
    end
  end

endmodule
